// ----- rtl/ntpcal_pkg.sv -----
// ----------------------------------------------------------------------------
// ntpcal_pkg
// constants, sequencer codes and calendar helpers for the ntp seconds to
// calendar converter
// ----------------------------------------------------------------------------
package ntpcal_pkg;

    localparam int unsigned SecsW      = 32;
    localparam int unsigned OffsetW    = 11;
    localparam int unsigned DaysW      = 16;
    localparam int unsigned YearW      = 12;
    localparam int unsigned MonthW     = 4;
    localparam int unsigned StepW      = 4;

    localparam logic [SecsW-1:0] EpochDiff  = 32'd2208988800;
    localparam logic [SecsW-1:0] SecsPerDay = 32'd86400;
    localparam logic [SecsW-1:0] SecsPerHr  = 32'd3600;
    localparam logic [SecsW-1:0] SecsPerMin = 32'd60;
    localparam logic [YearW-1:0] FirstYear  = 12'd1970;
    localparam logic [YearW-1:0] CentYear   = 12'd2100;

    localparam logic [StepW-1:0] DayStepTop  = 4'd15;
    localparam logic [StepW-1:0] HourStepTop = 4'd4;
    localparam logic [StepW-1:0] MinStepTop  = 4'd5;

    localparam logic [MonthW-1:0] MonthJan = 4'd0;
    localparam logic [MonthW-1:0] MonthFeb = 4'd1;
    localparam logic [MonthW-1:0] MonthDec = 4'd11;

    typedef logic [2:0] seq_state_t;

    localparam seq_state_t SeqIdle  = 3'd0;
    localparam seq_state_t SeqDay   = 3'd1;
    localparam seq_state_t SeqHour  = 3'd2;
    localparam seq_state_t SeqMin   = 3'd3;
    localparam seq_state_t SeqYear  = 3'd4;
    localparam seq_state_t SeqMonth = 3'd5;

    // exact over the reachable years 1970..2106
    function automatic logic is_leap(input logic [YearW-1:0] year);
        is_leap = (year[1:0] == 2'b00) && (year != CentYear);
    endfunction

    function automatic logic [SecsW-1:0] month_len(input logic [MonthW-1:0] month);
        logic [SecsW-1:0] len;
        len = 32'd31;
        unique case (month)
            4'd0:    len = 32'd31;
            4'd1:    len = 32'd28;
            4'd2:    len = 32'd31;
            4'd3:    len = 32'd30;
            4'd4:    len = 32'd31;
            4'd5:    len = 32'd30;
            4'd6:    len = 32'd31;
            4'd7:    len = 32'd31;
            4'd8:    len = 32'd30;
            4'd9:    len = 32'd31;
            4'd10:   len = 32'd30;
            4'd11:   len = 32'd31;
            default: len = 32'd31;
        endcase
        month_len = len;
    endfunction

endpackage

// ----- rtl/ntpcal_sub.sv -----
// ----------------------------------------------------------------------------
// ntpcal_sub
// shared compare and subtract unit used by every step of the sequencer
// ----------------------------------------------------------------------------
module ntpcal_sub (
    input  logic [ntpcal_pkg::SecsW-1:0] minuend,
    input  logic [ntpcal_pkg::SecsW-1:0] subtrahend,
    output logic [ntpcal_pkg::SecsW-1:0] difference,
    output logic                         no_borrow
);
    import ntpcal_pkg::*;

    logic [SecsW:0] wide_diff;

    assign wide_diff  = {1'b0, minuend} - {1'b0, subtrahend};
    assign difference = wide_diff[SecsW-1:0];
    assign no_borrow  = ~wide_diff[SecsW];

endmodule

// ----- rtl/ntp_seconds_to_calendar_unit.sv -----
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_unit
// converts an ntp seconds count plus a utc offset to date and time of day
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-----------------
//  config   | cfg_we, cfg_wdata                             | write on cfg_we
//  input    | start, busy, ntp_seconds                      | start & !busy
//  result   | done, day_of_month .. second_of_minute        | done, one cycle
//
//  one beat walks 16 steps for the day divide, 5 for hours, 6 for minutes,
//  one per year walked plus a closing compare, and one per month walked plus
//  a closing compare, all on the one shared subtractor.
//  busy is high from the accepting edge until the cycle done is high.
//  reset clears the sequencer and sets the offset to zero.
//  the result cannot be stalled; done lasts exactly one cycle.
// ----------------------------------------------------------------------------
module ntp_seconds_to_calendar_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ntpcal_pkg::OffsetW-1:0]   cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic [ntpcal_pkg::SecsW-1:0]     ntp_seconds,
    output logic                             done,
    output logic [4:0]                       day_of_month,
    output logic [3:0]                       month_number,
    output logic [ntpcal_pkg::YearW-1:0]     year_number,
    output logic [4:0]                       hour_of_day,
    output logic [5:0]                       minute_of_hour,
    output logic [5:0]                       second_of_minute
);
    import ntpcal_pkg::*;

    logic [OffsetW-1:0]  offset_reg;
    seq_state_t          state_reg, state_next;
    logic [StepW-1:0]    step_reg, step_next;
    logic [SecsW-1:0]    acc_reg, acc_next;
    logic [DaysW-1:0]    quot_reg, quot_next;
    logic [DaysW-1:0]    days_reg, days_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          min_reg, min_next;
    logic [5:0]          sec_reg, sec_next;
    logic [YearW-1:0]    year_reg, year_next;
    logic [MonthW-1:0]   month_reg, month_next;
    logic                done_reg, done_next;

    logic [SecsW-1:0]    sub_operand;
    logic [SecsW-1:0]    sub_diff;
    logic                sub_ge;
    logic [DaysW-1:0]    quot_shift;
    logic                leap;

    logic [SecsW-1:0]    epoch_secs;
    logic signed [16:0]  offset_secs;
    logic signed [33:0]  local_sum;
    logic [SecsW-1:0]    local_secs;

    assign epoch_secs  = ntp_seconds - EpochDiff;
    assign offset_secs = 17'(signed'(offset_reg)) * 17'sd60;
    assign local_sum   = signed'({2'b00, epoch_secs}) + 34'(offset_secs);
    assign local_secs  = local_sum[33] ? '0 : local_sum[SecsW-1:0];

    assign leap       = is_leap(year_reg);
    assign quot_shift = {quot_reg[DaysW-2:0], sub_ge};

    always_comb
    begin
        unique case (state_reg)
            SeqDay:   sub_operand = SecsPerDay << step_reg;
            SeqHour:  sub_operand = SecsPerHr << step_reg;
            SeqMin:   sub_operand = SecsPerMin << step_reg;
            SeqYear:  sub_operand = leap ? 32'd366 : 32'd365;
            SeqMonth: sub_operand = month_len(month_reg)
                                    + {31'd0, (month_reg == MonthFeb) && leap};
            default:  sub_operand = '0;
        endcase
    end

    ntpcal_sub u_sub (
        .minuend    (acc_reg),
        .subtrahend (sub_operand),
        .difference (sub_diff),
        .no_borrow  (sub_ge)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        quot_next  = quot_reg;
        days_next  = days_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        year_next  = year_reg;
        month_next = month_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            SeqIdle:
            begin
                if (start)
                begin
                    acc_next   = local_secs;
                    quot_next  = '0;
                    step_next  = DayStepTop;
                    state_next = SeqDay;
                end
            end
            SeqDay, SeqHour, SeqMin:
            begin
                quot_next = quot_shift;
                if (sub_ge)
                begin
                    acc_next = sub_diff;
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    quot_next = '0;
                    if (state_reg == SeqDay)
                    begin
                        days_next  = quot_shift;
                        step_next  = HourStepTop;
                        state_next = SeqHour;
                    end
                    else if (state_reg == SeqHour)
                    begin
                        hour_next  = quot_shift[4:0];
                        step_next  = MinStepTop;
                        state_next = SeqMin;
                    end
                    else
                    begin
                        min_next   = quot_shift[5:0];
                        sec_next   = sub_ge ? sub_diff[5:0] : acc_reg[5:0];
                        acc_next   = {{(SecsW-DaysW){1'b0}}, days_reg};
                        year_next  = FirstYear;
                        state_next = SeqYear;
                    end
                end
            end
            SeqYear:
            begin
                if (sub_ge)
                begin
                    acc_next  = sub_diff;
                    year_next = year_reg + 1'b1;
                end
                else
                begin
                    month_next = MonthJan;
                    state_next = SeqMonth;
                end
            end
            SeqMonth:
            begin
                if ((month_reg != MonthDec) && sub_ge)
                begin
                    acc_next   = sub_diff;
                    month_next = month_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = SeqIdle;
                end
            end
            default:
            begin
                state_next = SeqIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SeqIdle;
            done_reg   <= 1'b0;
            offset_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                offset_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        quot_reg  <= quot_next;
        days_reg  <= days_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        year_reg  <= year_next;
        month_reg <= month_next;
    end

    assign busy             = (state_reg != SeqIdle);
    assign done             = done_reg;
    assign day_of_month     = acc_reg[4:0] + 5'd1;
    assign month_number     = month_reg + 4'd1;
    assign year_number      = year_reg;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = min_reg;
    assign second_of_minute = sec_reg;

endmodule

// ----- tb/sv/tb_ntp_seconds_to_calendar_unit.sv -----
// ----------------------------------------------------------------------------
// tb_ntp_seconds_to_calendar_unit
// self-checking bench for the ntp seconds to calendar converter, directed
// epoch, calendar and offset corners plus weighted random beats
// ----------------------------------------------------------------------------
module tb_ntp_seconds_to_calendar_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] NtpUnixOffset = 32'd2208988800;
    localparam int unsigned SecondsPerDay = 86400;
    localparam int unsigned StallLimit    = 4000;
    localparam int unsigned BeatsPerPhase = 92;
    localparam int unsigned RandomPhases  = 8;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [ntpcal_pkg::OffsetW-1:0]       cfg_wdata = '0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [ntpcal_pkg::SecsW-1:0]         ntp_seconds = '0;
    logic                                 done;
    logic [4:0]                           day_of_month;
    logic [3:0]                           month_number;
    logic [ntpcal_pkg::YearW-1:0]         year_number;
    logic [4:0]                           hour_of_day;
    logic [5:0]                           minute_of_hour;
    logic [5:0]                           second_of_minute;

    logic signed [10:0] utc_offset_min = '0;
    calendar_t          pending_dates [$];
    calendar_t          oldest_date;
    int unsigned        mismatch_count = 0;
    int unsigned        conversions_sent = 0;
    int unsigned        results_checked = 0;
    int unsigned        offset_settings = 0;
    int unsigned        quiet_cycles = 0;

    ntp_seconds_to_calendar_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .start            (start),
        .busy             (busy),
        .ntp_seconds      (ntp_seconds),
        .done             (done),
        .day_of_month     (day_of_month),
        .month_number     (month_number),
        .year_number      (year_number),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int unsigned year_days(input int unsigned yr);
        if ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0)
            return 366;
        return 365;
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input int unsigned yr);
        case (mon)
            2:             return (year_days(yr) == 366) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic calendar_t calendar_of(input logic [31:0] raw,
                                              input logic signed [10:0] offset_min);
        logic [31:0] unix_secs;
        logic [31:0] local_secs;
        longint      shifted;
        longint      offset_secs;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        calendar_t   date;
        unix_secs   = raw - NtpUnixOffset;
        shifted     = unix_secs;
        offset_secs = offset_min;
        shifted     = shifted + offset_secs * 60;
        local_secs  = (shifted < 0) ? 32'd0 : shifted[31:0];
        days = local_secs / SecondsPerDay;
        tod  = local_secs % SecondsPerDay;
        yr   = 1970;
        while (days >= year_days(yr))
        begin
            days -= year_days(yr);
            yr++;
        end
        mon = 1;
        while (mon < 12 && days >= month_length(mon, yr))
        begin
            days -= month_length(mon, yr);
            mon++;
        end
        date.day    = 5'(days + 1);
        date.month  = 4'(mon);
        date.year   = 12'(yr);
        date.hour   = 5'(tod / 3600);
        date.minute = 6'((tod / 60) % 60);
        date.second = 6'(tod % 60);
        return date;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 4);
        if (roll < 95)
            return $urandom_range(5, 60);
        return $urandom_range(100, 400);
    endfunction

    // weighted toward local midnights, new years and both ends of the range
    function automatic logic [31:0] pick_seconds();
        int unsigned pick;
        int unsigned target_year;
        longint      day_count;
        longint      stamp;
        longint      offset_secs;
        int          jitter;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return $urandom();
        if (pick == 4)
            return NtpUnixOffset + $urandom_range(0, 200000);
        if (pick == 5)
            return NtpUnixOffset - 32'd1 - $urandom_range(0, 200000);
        if (pick < 9)
            day_count = $urandom_range(0, 49709);
        else
        begin
            day_count   = 0;
            target_year = $urandom_range(1971, 2106);
            for (int unsigned yr = 1970; yr < target_year; yr++)
                day_count += year_days(yr);
        end
        jitter      = $urandom_range(0, 60);
        jitter     -= 30;
        offset_secs = utc_offset_min;
        stamp       = day_count * SecondsPerDay - offset_secs * 60 + jitter;
        return NtpUnixOffset + stamp[31:0];
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_seconds(input logic [31:0] value);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        ntp_seconds <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_dates.push_back(calendar_of(value, utc_offset_min));
        conversions_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_dates.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic signed [10:0] minutes);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= minutes;
        @(posedge clk);
        cfg_we    <= 1'b0;
        utc_offset_min = minutes;
        offset_settings++;
    endtask

    task automatic test_epoch_edges();
        write_offset(11'sd0);
        send_seconds(NtpUnixOffset);
        send_seconds(NtpUnixOffset + 32'd1);
        send_seconds(NtpUnixOffset - 32'd1);
        send_seconds(32'h0000_0000);
        send_seconds(32'hFFFF_FFFF);
        send_seconds(32'h8000_0000);
    endtask

    task automatic test_calendar_edges();
        send_seconds(NtpUnixOffset + 32'd2678399);
        send_seconds(NtpUnixOffset + 32'd2678400);
        send_seconds(NtpUnixOffset + 32'd68169600);
        send_seconds(NtpUnixOffset + 32'd94694399);
        send_seconds(NtpUnixOffset + 32'd951825600);
        send_seconds(NtpUnixOffset + 32'd978307199);
        send_seconds(NtpUnixOffset + 32'd4107542399);
        send_seconds(NtpUnixOffset + 32'd4107542400);
    endtask

    task automatic test_offset_extremes();
        write_offset(-11'sd840);
        send_seconds(NtpUnixOffset);
        send_seconds(NtpUnixOffset + 32'd50399);
        send_seconds(NtpUnixOffset + 32'd50400);
        write_offset(11'sd840);
        send_seconds(NtpUnixOffset - 32'd1);
        send_seconds(NtpUnixOffset - 32'd50400);
        write_offset(11'h400);
        send_seconds(NtpUnixOffset + 32'd61439);
        send_seconds(32'h0000_0000);
        write_offset(11'h3FF);
        send_seconds(32'hFFFF_FFFF);
        write_offset(11'h7FF);
        send_seconds(NtpUnixOffset);
    endtask

    task automatic test_random_mix();
        logic signed [10:0] minutes;
        for (int unsigned phase = 0; phase < RandomPhases; phase++)
        begin
            case (phase)
                0:       minutes = 11'sd0;
                1:       minutes = -11'sd840;
                2:       minutes = 11'sd840;
                3:       minutes = 11'h400;
                4:       minutes = 11'h3FF;
                5:       minutes = 11'h7FF;
                default: minutes = 11'($urandom_range(0, 2047));
            endcase
            write_offset(minutes);
            repeat (BeatsPerPhase)
                send_seconds(pick_seconds());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                $error("result beat with no conversion outstanding");
                mismatch_count++;
            end
            else
            begin
                oldest_date = pending_dates.pop_front();
                check_field("day_of_month", oldest_date.day, day_of_month);
                check_field("month_number", oldest_date.month, month_number);
                check_field("year_number", oldest_date.year, year_number);
                check_field("hour_of_day", oldest_date.hour, hour_of_day);
                check_field("minute_of_hour", oldest_date.minute, minute_of_hour);
                check_field("second_of_minute", oldest_date.second, second_of_minute);
                results_checked++;
            end
        end
    end

    initial
    begin
        while (quiet_cycles < StallLimit)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_epoch_edges();
        test_calendar_edges();
        test_offset_extremes();
        test_random_mix();
        drain_results();
        repeat (180) @(posedge clk);
        if (pending_dates.size() != 0)
        begin
            $error("%0d conversions never returned a result", pending_dates.size());
            mismatch_count++;
        end
        $display("converted %0d ntp timestamps under %0d utc offset settings",
                 conversions_sent, offset_settings);
        $display("checked %0d results, %0d field mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
